[hdl/sspool_pkg.sv]
`timescale 1ns / 1ps
package sspool_pkg;

  localparam int SLOTS      = 8;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int FCNT_W     = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_INSTALL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_NO_READERS = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_id;
    logic [31:0] snapshot_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  granted_slot;
    logic [31:0] granted_handle;
    logic        freed_valid;
    logic [2:0]  freed_slot;
  } res_t;

endpackage

[hdl/sspool_core.sv]
`timescale 1ns / 1ps
module sspool_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_vld_i,
  input  sspool_pkg::req_t   req_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  output sspool_pkg::res_t   res_o
);
  import sspool_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [COUNT_BITS-1:0] cnt_q [SLOTS];
  logic [COUNT_BITS-1:0] cnt_d [SLOTS];
  logic [31:0]           hnd_q [SLOTS];
  logic [31:0]           hnd_d [SLOTS];
  logic                  occ_q [SLOTS];
  logic                  occ_d [SLOTS];
  logic [SLOT_W-1:0]     stk_q [SLOTS];
  logic [SLOT_W-1:0]     stk_d [SLOTS];
  logic [FCNT_W-1:0]     fc_q, fc_d;
  logic                  started_q, started_d;

  logic [SLOT_W-1:0]     sid;
  logic                  sid_bad;
  logic [SLOT_W-1:0]     rd_idx;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_occ;
  logic [FCNT_W-1:0]     fc_dec;
  logic [SLOT_W-1:0]     top_idx;
  logic [SLOT_W-1:0]     push_idx;
  logic [SLOT_W-1:0]     ns;

  always_comb begin
    sid      = SLOT_W'(req_i.slot_id);
    sid_bad  = int'(req_i.slot_id) >= SLOTS;
    // Release looks at the named slot; acquire and install at the current one.
    rd_idx   = (req_i.kind == KIND_RELEASE) ? sid : cur_q;
    rd_cnt   = cnt_q[rd_idx];
    rd_occ   = occ_q[rd_idx];
    fc_dec   = fc_q - FCNT_W'(1);
    top_idx  = SLOT_W'(fc_dec);
    push_idx = SLOT_W'(fc_q);
    ns       = stk_q[top_idx];

    cur_d     = cur_q;
    cnt_d     = cnt_q;
    hnd_d     = hnd_q;
    occ_d     = occ_q;
    stk_d     = stk_q;
    fc_d      = fc_q;
    started_d = started_q;
    res_o     = '0;

    if (cfg_we_i && !started_q) begin
      hnd_d[0] = cfg_data_i;
    end

    if (item_vld_i) begin
      started_d = 1'b1;
      case (req_i.kind)
        KIND_ACQUIRE: begin
          res_o.granted_slot   = 3'(cur_q);
          res_o.granted_handle = hnd_q[cur_q];
          if (rd_cnt == CNT_MAX) begin
            res_o.status = ST_OVERFLOW;
          end else begin
            cnt_d[cur_q] = rd_cnt + CNT_ONE;
          end
        end
        KIND_RELEASE: begin
          if (sid_bad) begin
            res_o.status = ST_BAD_INDEX;
          end else if (rd_cnt == '0) begin
            res_o.status = ST_NO_READERS;
          end else begin
            cnt_d[sid] = rd_cnt - CNT_ONE;
            if (rd_cnt == CNT_ONE && sid != cur_q && rd_occ) begin
              hnd_d[sid] = '0;
              occ_d[sid] = 1'b0;
              // The slot is cleared even when the stack has no room for it.
              if (int'(fc_q) < SLOTS) begin
                stk_d[push_idx]   = sid;
                fc_d              = fc_q + FCNT_W'(1);
                res_o.freed_valid = 1'b1;
                res_o.freed_slot  = 3'(sid);
              end
            end
          end
        end
        KIND_INSTALL: begin
          if (fc_q == '0) begin
            res_o.status = ST_EXHAUSTED;
          end else begin
            fc_d                 = fc_dec;
            hnd_d[ns]            = req_i.snapshot_handle;
            occ_d[ns]            = 1'b1;
            cnt_d[ns]            = '0;
            cur_d                = ns;
            res_o.granted_slot   = 3'(ns);
            res_o.granted_handle = req_i.snapshot_handle;
            // The old slot goes back into the place just popped, so the
            // fill count is left as it was.
            if (rd_cnt == '0 && cur_q != ns && rd_occ) begin
              hnd_d[cur_q]      = '0;
              occ_d[cur_q]      = 1'b0;
              stk_d[top_idx]    = cur_q;
              fc_d              = fc_q;
              res_o.freed_valid = 1'b1;
              res_o.freed_slot  = 3'(cur_q);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      fc_q      <= FCNT_W'(SLOTS - 1);
      started_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        cnt_q[i] <= '0;
        hnd_q[i] <= '0;
        occ_q[i] <= (i == 0);
        stk_q[i] <= SLOT_W'(i + 1);
      end
    end else begin
      cur_q     <= cur_d;
      fc_q      <= fc_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      hnd_q     <= hnd_d;
      occ_q     <= occ_d;
      stk_q     <= stk_d;
    end
  end

endmodule

[hdl/snapshot_slot_refcount_pool_unit.sv]
`timescale 1ns / 1ps
// A start beat goes into the input registers; its result is registered onto done_o.
// Throughput: one item per cycle; the slot tables are small register files
// read and written between the input and result registers.
// busy is never asserted and the receiver cannot stall the results.
// Reset: slot zero is current and occupied, slots one upwards sit on the free stack.
module snapshot_slot_refcount_pool_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sspool_pkg::req_t req_i,
  output logic             done_o,
  output sspool_pkg::res_t res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_data_i
);
  import sspool_pkg::*;

  req_t req_q;
  logic vld_q;
  res_t res_q;
  res_t res_d;
  logic done_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start && !busy;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  sspool_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (vld_q),
    .req_i      (req_q),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_d)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[tb/tb_snapshot_slot_refcount_pool_unit.sv]
`timescale 1ns / 1ps
module tb_snapshot_slot_refcount_pool_unit;
  import sspool_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  req_t        req_i       = '0;
  logic        done_o;
  res_t        res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  snapshot_slot_refcount_pool_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("snapshot_slot_refcount_pool_unit test failed");
    $finish;
  end

  // Shadow of the pool, advanced once per accepted beat.
  logic [SLOT_W-1:0]     shadow_cur;
  logic [COUNT_BITS-1:0] readers  [SLOTS];
  logic [31:0]           handles  [SLOTS];
  logic                  occupied [SLOTS];
  logic [SLOT_W-1:0]     free_stk [SLOTS];
  int                    free_cnt;
  logic                  item_seen;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   fail_count  = 0;
  int   idle_left   = 0;
  bit   sender_idle = 1'b1;

  function automatic void reset_pool_model();
    shadow_cur = '0;
    item_seen  = 1'b0;
    free_cnt   = 0;
    for (int i = 0; i < SLOTS; i++) begin
      readers[i]  = '0;
      handles[i]  = '0;
      occupied[i] = 1'b0;
      free_stk[i] = '0;
    end
    occupied[0] = 1'b1;
    for (int i = 1; i < SLOTS; i++) begin
      free_stk[free_cnt] = SLOT_W'(i);
      free_cnt++;
    end
  endfunction

  function automatic bit retire_slot(logic [SLOT_W-1:0] s);
    handles[s]  = '0;
    occupied[s] = 1'b0;
    if (free_cnt >= SLOTS) return 1'b0;
    free_stk[free_cnt] = s;
    free_cnt++;
    return 1'b1;
  endfunction

  function automatic res_t predict_pool_step(req_t r);
    res_t              o;
    logic [SLOT_W-1:0] sid;
    logic [SLOT_W-1:0] ns;
    logic [SLOT_W-1:0] old;
    o = '0;
    sid = r.slot_id[SLOT_W-1:0];
    item_seen = 1'b1;
    case (r.kind)
      KIND_ACQUIRE: begin
        o.granted_slot   = shadow_cur;
        o.granted_handle = handles[shadow_cur];
        if (readers[shadow_cur] == COUNT_FULL) o.status = ST_OVERFLOW;
        else readers[shadow_cur]++;
      end
      KIND_RELEASE: begin
        if (r.slot_id >= SLOTS) begin
          o.status = ST_BAD_INDEX;
        end else if (readers[sid] == '0) begin
          o.status = ST_NO_READERS;
        end else begin
          readers[sid]--;
          if (readers[sid] == '0 && sid != shadow_cur && occupied[sid]) begin
            if (retire_slot(sid)) begin
              o.freed_valid = 1'b1;
              o.freed_slot  = sid;
            end
          end
        end
      end
      KIND_INSTALL: begin
        if (free_cnt == 0) begin
          o.status = ST_EXHAUSTED;
        end else begin
          free_cnt--;
          ns           = free_stk[free_cnt];
          handles[ns]  = r.snapshot_handle;
          occupied[ns] = 1'b1;
          readers[ns]  = '0;
          old          = shadow_cur;
          shadow_cur   = ns;
          o.granted_slot   = ns;
          o.granted_handle = r.snapshot_handle;
          if (readers[old] == '0 && old != ns && occupied[old]) begin
            if (retire_slot(old)) begin
              o.freed_valid = 1'b1;
              o.freed_slot  = old;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Results are checked before the beat taken at the same edge is predicted.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (!rst_ni) begin
      reset_pool_model();
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no outstanding item: %p", res_o);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", 32'(exp_r.status), 32'(res_o.status));
          check_field("granted_slot", 32'(exp_r.granted_slot), 32'(res_o.granted_slot));
          check_field("granted_handle", exp_r.granted_handle, res_o.granted_handle);
          check_field("freed_valid", 32'(exp_r.freed_valid), 32'(res_o.freed_valid));
          check_field("freed_slot", 32'(exp_r.freed_slot), 32'(res_o.freed_slot));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (!item_seen) handles[0] = cfg_data_i;
      end
      if (start && !busy)
        expected_results.insert(expected_results.size(), predict_pool_step(req_i));
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      req_i     <= '0;
      idle_left <= 0;
    end else if (!start || !busy) begin
      if (idle_left > 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_reqs.size() > 0) begin
        start     <= 1'b1;
        req_i     <= pending_reqs.pop_front();
        idle_left <= sender_idle ? int'($urandom_range(0, 3)) : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic wait_for_room();
    while (pending_reqs.size() >= 2) @(negedge clk_i);
  endtask

  task automatic queue_item(input logic [1:0] kind, input logic [3:0] sid,
                            input logic [31:0] hnd);
    req_t r;
    r.kind            = kind;
    r.slot_id         = sid;
    r.snapshot_handle = hnd;
    wait_for_room();
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Waits until every beat has been taken and answered.
  task automatic drain_pool_traffic();
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_initial_handle(input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] random_handle();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic: releases go to slots that really hold readers,
  // preferring old snapshots so that their last reader frees them.
  task automatic queue_random_item(input int acq_w, input int rel_w, input int inst_w);
    int          roll;
    int          pinned[$];
    int          stale[$];
    logic [3:0]  sid;
    wait_for_room();
    roll = $urandom_range(0, 99);
    if (roll < acq_w) begin
      queue_item(KIND_ACQUIRE, 4'($urandom_range(0, 15)), random_handle());
    end else if (roll < acq_w + rel_w) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (readers[i] != '0) begin
          pinned.insert(pinned.size(), i);
          if (i != shadow_cur) stale.insert(stale.size(), i);
        end
      end
      if (stale.size() > 0 && $urandom_range(0, 3) != 0)
        sid = 4'(stale[$urandom_range(0, stale.size() - 1)]);
      else if (pinned.size() > 0)
        sid = 4'(pinned[$urandom_range(0, pinned.size() - 1)]);
      else
        sid = 4'($urandom_range(0, SLOTS - 1));
      queue_item(KIND_RELEASE, sid, random_handle());
    end else if (roll < acq_w + rel_w + inst_w) begin
      queue_item(KIND_INSTALL, 4'($urandom_range(0, 15)), random_handle());
    end else begin
      case ($urandom_range(0, 2))
        0:       queue_item(KIND_RELEASE, 4'($urandom_range(0, 15)), random_handle());
        1:       queue_item(KIND_UNUSED, 4'($urandom_range(0, 15)), random_handle());
        default: queue_item(KIND_RELEASE, 4'($urandom_range(0, SLOTS - 1)), $urandom);
      endcase
    end
  endtask

  initial begin
    int fill;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Both writes land before the first item, so each reloads slot zero.
    write_initial_handle($urandom);
    write_initial_handle(32'hFFFF_FFFF);

    queue_item(KIND_ACQUIRE, 4'd0, 32'h0);
    queue_item(KIND_RELEASE, 4'd0, 32'h0);
    queue_item(KIND_RELEASE, 4'd0, 32'h0);
    queue_item(KIND_RELEASE, 4'd15, 32'hFFFF_FFFF);
    queue_item(KIND_RELEASE, 4'd8, 32'h0);
    queue_item(KIND_UNUSED, 4'd15, 32'hFFFF_FFFF);
    queue_item(KIND_INSTALL, 4'd0, 32'hFFFF_FFFF);
    queue_item(KIND_ACQUIRE, 4'd0, 32'h0);
    queue_item(KIND_INSTALL, 4'd0, 32'h0000_0000);
    queue_item(KIND_RELEASE, 4'd7, 32'h0);
    // Pin every new snapshot before replacing it until the free stack runs dry.
    for (int i = 0; i < SLOTS - 1; i++) begin
      queue_item(KIND_ACQUIRE, 4'd0, 32'h0);
      queue_item(KIND_INSTALL, 4'd0, $urandom);
    end
    queue_item(KIND_INSTALL, 4'd0, 32'h1234_5678);
    drain_pool_traffic();

    write_initial_handle(32'h0000_0000);
    for (int i = 0; i < 900; i++) queue_random_item(40, 30, 22);
    drain_pool_traffic();

    write_initial_handle($urandom);
    sender_idle = 1'b0;
    for (int i = 0; i < 600; i++) queue_random_item(30, 45, 17);
    drain_pool_traffic();

    // Let every old snapshot go so that the next install finds free slots.
    for (int s = 0; s < SLOTS; s++) begin
      if (s != shadow_cur) begin
        fill = int'(readers[s]);
        for (int k = 0; k < fill; k++) queue_item(KIND_RELEASE, 4'(s), $urandom);
      end
    end
    drain_pool_traffic();

    fill = int'(shadow_cur);
    queue_item(KIND_INSTALL, 4'd0, $urandom);
    queue_item(KIND_RELEASE, 4'(fill), $urandom);
    queue_item(KIND_ACQUIRE, 4'd0, $urandom);
    drain_pool_traffic();

    write_initial_handle(32'hFFFF_FFFF);
    sender_idle = 1'b1;
    for (int i = 0; i < 350; i++) queue_random_item(35, 40, 17);
    drain_pool_traffic();

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("snapshot_slot_refcount_pool_unit test passed");
    end else begin
      $display("snapshot_slot_refcount_pool_unit test failed");
    end
    $finish;
  end

endmodule
